@@ hw/rtl/bptp_pkg.sv @@
package bptp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TOK_W    = 3;
  localparam int unsigned DENS_W   = 17;
  localparam int unsigned ENER_W   = 18;
  localparam int unsigned PROTO_W  = 3;
  localparam int unsigned CIPHER_W = 2;
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned BCNT_W   = 25;
  localparam int unsigned TCNT_W   = 27;
  localparam int unsigned ESUM_W   = 28;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CIDX_W   = 1;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_W    = ESUM_W + FRAC_W;
  localparam int unsigned DCNT_W   = 6;

  localparam logic [BCNT_W-1:0] MAX_STREAM_BYTES = 25'd16777216;
  localparam logic [HASH_W-1:0] FNV_OFFSET       = 64'hcbf29ce484222325;
  localparam logic [HASH_W-1:0] FNV_PRIME_LO     = 64'h1b3;
  localparam logic [DCNT_W-1:0] DIV_LAST_STEP    = 6'(NUM_W - 1);

  localparam logic [CFG_W-1:0] ENCRYPTED_BELOW_RST = 17'd27525;
  localparam logic [CFG_W-1:0] PLAINTEXT_ABOVE_RST = 17'd36045;

  localparam logic [CIDX_W-1:0] REG_ENCRYPTED_BELOW = 1'd0;
  localparam logic [CIDX_W-1:0] REG_PLAINTEXT_ABOVE = 1'd1;

  localparam logic [PROTO_W-1:0] PROTO_HTTP    = 3'd0;
  localparam logic [PROTO_W-1:0] PROTO_TLS     = 3'd1;
  localparam logic [PROTO_W-1:0] PROTO_DNS     = 3'd2;
  localparam logic [PROTO_W-1:0] PROTO_SSH     = 3'd3;
  localparam logic [PROTO_W-1:0] PROTO_SMTP    = 3'd4;
  localparam logic [PROTO_W-1:0] PROTO_BINARY  = 3'd5;
  localparam logic [PROTO_W-1:0] PROTO_UNKNOWN = 3'd6;

  localparam logic [CIPHER_W-1:0] CIPHER_ENCRYPTED = 2'd0;
  localparam logic [CIPHER_W-1:0] CIPHER_PLAINTEXT = 2'd1;
  localparam logic [CIPHER_W-1:0] CIPHER_MIXED     = 2'd2;

  localparam int unsigned NUM_PROTO = 6;

  localparam logic [DENS_W-1:0] PROTO_ID_LO [NUM_PROTO] =
    '{17'd32768, 17'd22938, 17'd39322, 17'd22938, 17'd32768, 17'd27525};
  localparam logic [DENS_W-1:0] PROTO_ID_HI [NUM_PROTO] =
    '{17'd49152, 17'd27525, 17'd52429, 17'd27525, 17'd45875, 17'd36045};
  localparam logic [DENS_W-1:0] PROTO_E_MAX [NUM_PROTO] =
    '{17'd52429, 17'd78643, 17'd39322, 17'd78643, 17'd52429, 17'd65536};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  function automatic logic [TOK_W-1:0] token_f(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b,
                                               input logic [2:0] idx);
    logic [1:0] i;
    logic ea, oa, eb, ob;
    logic [TOK_W-1:0] t;
    i  = idx[1:0];
    ea = a[{~i, 1'b1}];
    oa = a[{~i, 1'b0}];
    eb = b[{~i, 1'b1}];
    ob = b[{~i, 1'b0}];
    if (idx[2]) begin
      t = 3'(ea) + 3'(ob) + 3'd2 - 3'(oa) - 3'(eb);
    end else begin
      t = 3'(ea) + 3'(oa) + 3'd2 - 3'(eb) - 3'(ob);
    end
    return t;
  endfunction

  function automatic logic [PROTO_W-1:0] proto_class_f(input logic [DENS_W-1:0] dens,
                                                       input logic [ENER_W-1:0] ener);
    logic [PROTO_W-1:0] cls;
    cls = PROTO_UNKNOWN;
    for (int k = NUM_PROTO - 1; k >= 0; k--) begin
      if (dens >= PROTO_ID_LO[k] && dens <= PROTO_ID_HI[k] &&
          ener <= {1'b0, PROTO_E_MAX[k]}) begin
        cls = PROTO_W'(k);
      end
    end
    return cls;
  endfunction

endpackage

@@ hw/rtl/byte_pair_traffic_profiler.sv @@
// Byte-pair traffic profiler. Bytes of one stream arrive one per input
// transaction, the final one flagged by last_byte_i; one result transaction
// follows each flagged byte. Every byte after the first of a stream is paired
// with its predecessor and yields eight tokens, which are folded into the
// FNV-1a hash one per cycle by a single shared hash step (xor, multiply by a
// 9-bit constant plus a 40-bit shift), so the input stalls while such a byte
// is hashed; the first byte of a stream, or a byte dropped past the 2^24 byte
// bound, takes no hash step. A flagged byte then runs one restoring divider
// twice (density, then energy), each run a load state then the divide steps,
// and issues the result once the output is free. The result waits in an
// output register, so the next stream's bytes are taken while it is held.
// Configuration writes take effect at once and are meant for idle periods.
module byte_pair_traffic_profiler (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bptp_pkg::CIDX_W-1:0]        cfg_index_i,
  input  logic [bptp_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bptp_pkg::BYTE_W-1:0]        byte_value_i,
  input  logic                               last_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bptp_pkg::DENS_W-1:0]        density_q16_o,
  output logic [bptp_pkg::ENER_W-1:0]        energy_q16_o,
  output logic [bptp_pkg::PROTO_W-1:0]       protocol_class_o,
  output logic [bptp_pkg::CIPHER_W-1:0]      cipher_class_o,
  output logic [bptp_pkg::HASH_W-1:0]        stream_hash_o,
  output logic [bptp_pkg::BCNT_W-1:0]        bytes_seen_o,
  output logic [bptp_pkg::TCNT_W-1:0]        tokens_seen_o,
  output logic                               count_overflow_o
);
  import bptp_pkg::*;

  state_e state_q, state_d;

  logic [CFG_W-1:0]  enc_below_q, plain_above_q;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic [BYTE_W-1:0] pair_a_q, pair_a_d;
  logic              have_prev_q, have_prev_d;
  logic [TCNT_W-1:0] ident_q, ident_d;
  logic [TCNT_W-1:0] tok_total_q, tok_total_d;
  logic [ESUM_W-1:0] esum_q, esum_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [BCNT_W-1:0] byte_total_q, byte_total_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;
  logic [2:0]        tok_idx_q, tok_idx_d;
  logic              phase_q, phase_d;

  logic [NUM_W-1:0]  num_q, num_d;
  logic [TCNT_W-1:0] rem_q, rem_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [DENS_W-1:0] dens_q, dens_d;
  logic [ENER_W-1:0] ener_q, ener_d;

  logic              out_valid_q, out_valid_d;
  logic [DENS_W-1:0]   out_dens_q, out_dens_d;
  logic [ENER_W-1:0]   out_ener_q, out_ener_d;
  logic [PROTO_W-1:0]  out_proto_q, out_proto_d;
  logic [CIPHER_W-1:0] out_cipher_q, out_cipher_d;
  logic [HASH_W-1:0]   out_hash_q, out_hash_d;
  logic [BCNT_W-1:0]   out_bytes_q, out_bytes_d;
  logic [TCNT_W-1:0]   out_toks_q, out_toks_d;
  logic                out_ovf_q, out_ovf_d;

  // shared token / hash step
  logic [BYTE_W-1:0] tok_a, tok_b;
  logic [TOK_W-1:0]  tok;
  logic [1:0]        tok_off;
  logic [HASH_W-1:0] hx, hx_lo, hash_step;

  assign tok_a     = (state_q == ST_IDLE) ? prev_q : pair_a_q;
  assign tok_b     = (state_q == ST_IDLE) ? byte_value_i : prev_q;
  assign tok       = token_f(tok_a, tok_b, tok_idx_q);
  assign tok_off   = (tok >= 3'd2) ? 2'(tok - 3'd2) : 2'(3'd2 - tok);
  assign hx        = hash_q ^ {{(HASH_W-TOK_W){1'b0}}, tok};
  assign hx_lo     = hx * FNV_PRIME_LO;
  assign hash_step = {hx[HASH_W-41:0], 40'b0} + hx_lo;

  // shared divider step
  logic [TCNT_W:0]   trial;
  logic              ge;
  logic [NUM_W-1:0]  num_step;

  assign trial    = {rem_q, num_q[NUM_W-1]};
  assign ge       = trial >= {1'b0, tok_total_q};
  assign num_step = {num_q[NUM_W-2:0], ge};

  logic              accept, do_token, out_free, no_tokens;
  logic [DENS_W-1:0] dens_fin;
  logic [ENER_W-1:0] ener_fin;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign no_tokens = (tok_total_q == '0);
  assign dens_fin  = no_tokens ? '0 : dens_q;
  assign ener_fin  = no_tokens ? '0 : ener_q;

  always_comb begin
    state_d      = state_q;
    prev_d       = prev_q;
    pair_a_d     = pair_a_q;
    have_prev_d  = have_prev_q;
    ident_d      = ident_q;
    tok_total_d  = tok_total_q;
    esum_d       = esum_q;
    hash_d       = hash_q;
    byte_total_d = byte_total_q;
    ovf_d        = ovf_q;
    last_d       = last_q;
    tok_idx_d    = tok_idx_q;
    phase_d      = phase_q;
    num_d        = num_q;
    rem_d        = rem_q;
    dcnt_d       = dcnt_q;
    dens_d       = dens_q;
    ener_d       = ener_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_dens_d   = out_dens_q;
    out_ener_d   = out_ener_q;
    out_proto_d  = out_proto_q;
    out_cipher_d = out_cipher_q;
    out_hash_d   = out_hash_q;
    out_bytes_d  = out_bytes_q;
    out_toks_d   = out_toks_q;
    out_ovf_d    = out_ovf_q;
    do_token     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = last_byte_i;
          if (byte_total_q >= MAX_STREAM_BYTES) begin
            ovf_d = 1'b1;
            if (last_byte_i) begin
              phase_d = 1'b0;
              state_d = ST_LOAD;
            end
          end else begin
            byte_total_d = byte_total_q + 1'b1;
            prev_d       = byte_value_i;
            pair_a_d     = prev_q;
            have_prev_d  = 1'b1;
            if (have_prev_q) begin
              do_token = 1'b1;
              state_d  = ST_HASH;
            end else if (last_byte_i) begin
              phase_d = 1'b0;
              state_d = ST_LOAD;
            end
          end
        end
      end
      ST_HASH: begin
        do_token = 1'b1;
        if (tok_idx_q == 3'd7) begin
          if (last_q) begin
            phase_d = 1'b0;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        num_d   = phase_q ? {esum_q, {FRAC_W{1'b0}}} : {1'b0, ident_q, {FRAC_W{1'b0}}};
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        num_d  = num_step;
        rem_d  = ge ? TCNT_W'(trial - {1'b0, tok_total_q}) : TCNT_W'(trial);
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DIV_LAST_STEP) begin
          if (!phase_q) begin
            dens_d  = num_step[DENS_W-1:0];
            phase_d = 1'b1;
            state_d = ST_LOAD;
          end else begin
            ener_d  = num_step[ENER_W-1:0];
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_dens_d   = dens_fin;
          out_ener_d   = ener_fin;
          out_proto_d  = proto_class_f(dens_fin, ener_fin);
          if (dens_fin < enc_below_q) begin
            out_cipher_d = CIPHER_ENCRYPTED;
          end else if (dens_fin > plain_above_q) begin
            out_cipher_d = CIPHER_PLAINTEXT;
          end else begin
            out_cipher_d = CIPHER_MIXED;
          end
          out_hash_d   = hash_q;
          out_bytes_d  = byte_total_q;
          out_toks_d   = tok_total_q;
          out_ovf_d    = ovf_q;
          prev_d       = '0;
          have_prev_d  = 1'b0;
          ident_d      = '0;
          tok_total_d  = '0;
          esum_d       = '0;
          hash_d       = FNV_OFFSET;
          byte_total_d = '0;
          ovf_d        = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_token) begin
      ident_d     = ident_q + TCNT_W'(tok == 3'd2);
      esum_d      = esum_q + ESUM_W'(tok_off);
      tok_total_d = tok_total_q + 1'b1;
      hash_d      = hash_step;
      tok_idx_d   = tok_idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      enc_below_q   <= ENCRYPTED_BELOW_RST;
      plain_above_q <= PLAINTEXT_ABOVE_RST;
      prev_q        <= '0;
      have_prev_q   <= 1'b0;
      ident_q       <= '0;
      tok_total_q   <= '0;
      esum_q        <= '0;
      hash_q        <= FNV_OFFSET;
      byte_total_q  <= '0;
      ovf_q         <= 1'b0;
      last_q        <= 1'b0;
      tok_idx_q     <= '0;
      phase_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      prev_q       <= prev_d;
      have_prev_q  <= have_prev_d;
      ident_q      <= ident_d;
      tok_total_q  <= tok_total_d;
      esum_q       <= esum_d;
      hash_q       <= hash_d;
      byte_total_q <= byte_total_d;
      ovf_q        <= ovf_d;
      last_q       <= last_d;
      tok_idx_q    <= tok_idx_d;
      phase_q      <= phase_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENCRYPTED_BELOW: enc_below_q   <= cfg_data_i;
          REG_PLAINTEXT_ABOVE: plain_above_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pair_a_q     <= pair_a_d;
    num_q        <= num_d;
    rem_q        <= rem_d;
    dcnt_q       <= dcnt_d;
    dens_q       <= dens_d;
    ener_q       <= ener_d;
    out_dens_q   <= out_dens_d;
    out_ener_q   <= out_ener_d;
    out_proto_q  <= out_proto_d;
    out_cipher_q <= out_cipher_d;
    out_hash_q   <= out_hash_d;
    out_bytes_q  <= out_bytes_d;
    out_toks_q   <= out_toks_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign density_q16_o    = out_dens_q;
  assign energy_q16_o     = out_ener_q;
  assign protocol_class_o = out_proto_q;
  assign cipher_class_o   = out_cipher_q;
  assign stream_hash_o    = out_hash_q;
  assign bytes_seen_o     = out_bytes_q;
  assign tokens_seen_o    = out_toks_q;
  assign count_overflow_o = out_ovf_q;

`ifndef SYNTHESIS
  a_tokens_per_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bytes_seen_o != '0 |->
      tokens_seen_o == (TCNT_W'(bytes_seen_o - 1'b1) << 3))
    else $error("token count does not match byte count");

  a_no_tokens_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tokens_seen_o == '0 |-> density_q16_o == '0 && energy_q16_o == '0)
    else $error("nonzero quotient for empty token set");

  a_byte_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bytes_seen_o <= MAX_STREAM_BYTES &&
      (!count_overflow_o || bytes_seen_o == MAX_STREAM_BYTES))
    else $error("byte count past bound");

  a_ssh_shadowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> protocol_class_o != PROTO_SSH)
    else $error("shadowed protocol entry selected");
`endif

endmodule
